// ===== hdl/double_ended_queue_with_search_macros.svh =====
// ----------------------------------------------------------------------------
// double_ended_queue_with_search_macros
// Assertion macros used by the deque RTL in dqs_ctrl; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
// property checked on i_clk, off while reset is low
`define DQS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("deque assertion failed");
// property checked on i_clk, reset included
`define DQS_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("deque reset assertion failed");
`else
`define DQS_ASSERT(lbl, prop)
`define DQS_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== hdl/dqs_pkg.sv =====
// ----------------------------------------------------------------------------
// dqs_pkg
// Types, constants and ring arithmetic for the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dqs_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int FUNC_W = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    typedef logic [FUNC_W-1:0] t_func;

    localparam t_func FN_PUSH_FRONT = 3'd0;
    localparam t_func FN_PUSH_BACK  = 3'd1;
    localparam t_func FN_POP_FRONT  = 3'd2;
    localparam t_func FN_POP_BACK   = 3'd3;
    localparam t_func FN_PEEK_FRONT = 3'd4;
    localparam t_func FN_PEEK_BACK  = 3'd5;
    localparam t_func FN_SEARCH     = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd2;

    typedef struct packed {
        t_func                    func;
        logic signed [DATA_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] data;
        logic                     found;
        logic [OCC_W-1:0]         occupancy;
    } t_out;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RDWAIT,
        S_SCAN,
        S_DONE
    } t_state;

    // base + off modulo DEPTH, valid for base + off < 2*DEPTH
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dqs_store.sv =====
// ----------------------------------------------------------------------------
// dqs_store
// Element ring store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dqs_store
    import dqs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_mem_req          i_req,
    output logic [DATA_W-1:0]      o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/dqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dqs_ctrl
// Operation sequencer: ring pointers, store access and the scan comparator.
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_ended_queue_with_search_macros.svh"

module dqs_ctrl
    import dqs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in               i_in_data,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output t_out                   o_res,
    output t_mem_req               o_mem_req,
    input  wire logic [DATA_W-1:0] i_mem_rdata
);

    t_state            r_state, n_state;
    t_func             r_func, n_func;
    logic [DATA_W-1:0] r_value, n_value;
    logic [ADDR_W-1:0] r_front, n_front;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [STAT_W-1:0] r_status, n_status;
    logic [DATA_W-1:0] r_data, n_data;
    logic              r_found, n_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_value  <= n_value;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_data   <= n_data;
        r_found  <= n_found;
    end

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_value   = r_value;
        n_front   = r_front;
        n_count   = r_count;
        n_idx     = r_idx;
        n_status  = r_status;
        n_data    = r_data;
        n_found   = r_found;
        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = ring_add(r_front, r_count);
        o_mem_req.wdata = r_value;
        o_mem_req.raddr = ring_add(r_front, r_idx + 1'b1);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func  = i_in_data.func;
                    n_value = i_in_data.value;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status = ST_OK;
                n_data   = '0;
                n_found  = 1'b0;
                n_state  = S_DONE;
                if (r_func inside {FN_PUSH_FRONT, FN_PUSH_BACK}) begin
                    if (r_count >= CNT_W'(DEPTH)) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        o_mem_req.we = 1'b1;
                        n_count      = r_count + 1'b1;
                        if (r_func == FN_PUSH_FRONT) begin
                            o_mem_req.waddr = ring_add(r_front, CNT_W'(DEPTH - 1));
                            n_front         = ring_add(r_front, CNT_W'(DEPTH - 1));
                        end
                    end
                end else if (r_func inside {FN_POP_FRONT, FN_POP_BACK,
                                            FN_PEEK_FRONT, FN_PEEK_BACK}) begin
                    if (r_count == '0) begin
                        n_status = ST_UNDERFLOW;
                    end else begin
                        n_state = S_RDWAIT;
                        if (r_func inside {FN_POP_FRONT, FN_PEEK_FRONT}) begin
                            o_mem_req.raddr = r_front;
                        end else begin
                            o_mem_req.raddr = ring_add(r_front, r_count - 1'b1);
                        end
                        if (r_func == FN_POP_FRONT) begin
                            n_front = ring_add(r_front, CNT_W'(1));
                        end
                        if (r_func inside {FN_POP_FRONT, FN_POP_BACK}) begin
                            n_count = r_count - 1'b1;
                        end
                    end
                end else if (r_func == FN_SEARCH) begin
                    if (r_count != '0) begin
                        o_mem_req.raddr = r_front;
                        n_idx           = '0;
                        n_state         = S_SCAN;
                    end
                end
            end
            S_RDWAIT: begin
                n_data  = i_mem_rdata;
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (i_mem_rdata == r_value) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else if (r_idx == r_count - 1'b1) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_res_valid     = (r_state == S_DONE);
    assign o_res.status    = r_status;
    assign o_res.data      = r_data;
    assign o_res.found     = r_found;
    assign o_res.occupancy = OCC_W'(r_count);

    `DQS_ASSERT(a_count_bound, r_count <= CNT_W'(DEPTH))
    `DQS_ASSERT(a_scan_idx, (r_state == S_SCAN) |-> (r_idx < r_count))
    `DQS_ASSERT(a_push_grows, (r_state == S_DECODE && (r_func == FN_PUSH_FRONT || r_func == FN_PUSH_BACK) && r_count < CNT_W'(DEPTH)) |=> (r_count == $past(r_count) + 1'b1))
    `DQS_ASSERT(a_done_holds, (r_state == S_DONE && !i_res_ready) |=> (r_state == S_DONE && $stable(r_status) && $stable(r_count)))
    `DQS_ASSERT_RST(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE && r_count == '0))

endmodule

`default_nettype wire

// ===== hdl/double_ended_queue_with_search.sv =====
// Flow: push and failed ops go from decode to done, as does search on an empty queue;
//   pop/peek pass a read-wait state; search scans from the front to a match or the end.
// A new beat is taken only while idle, after the previous reply has left the sequencer;
//   the scan compares one stored entry per cycle through the single read port.
// Reset (synchronous, i_rst_n low): queue empty, front at 0, no output pending.
// ----------------------------------------------------------------------------
// double_ended_queue_with_search
// Bounded deque with push/pop/peek at both ends and a linear value search.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_with_search
    import dqs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    logic              res_valid;
    logic              res_ready;
    t_out              res;
    t_mem_req          mem_req;
    logic [DATA_W-1:0] mem_rdata;
    logic              r_out_valid;
    t_out              r_out;

    dqs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    dqs_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== tb/double_ended_queue_with_search_tb.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_with_search_tb
// Drives push, pop, peek, search and no-op beats into the deque with random gaps on
// both channels. A behavioral deque in the bench predicts each reply, and the
// replies are checked in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_with_search_tb;
    import dqs_pkg::*;

    localparam t_func FN_NOP      = 3'd7;
    localparam int    STALL_LIMIT = 2000;
    localparam int    RANDOM_OPS  = 1200;
    localparam int    DRAIN_WAIT  = 3 * DEPTH;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    t_in  pending_ops[$];
    t_out predicted_replies[$];

    logic [DATA_W-1:0] model_store[DEPTH];
    logic [ADDR_W-1:0] model_front = '0;
    logic [CNT_W-1:0]  model_count = '0;

    int beats_in     = 0;
    int beats_out    = 0;
    int errors       = 0;
    int stall_cycles = 0;
    int func_seen[8] = '{default: 0};
    int underflows   = 0;
    int overflows    = 0;
    int search_hits  = 0;
    logic quiet;

    double_ended_queue_with_search i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // no gaps on either side for a stretch in the middle of the run
    assign quiet = (beats_in >= 500) && (beats_in < 750);

    function automatic t_out deque_apply(input t_in op);
        t_out              r;
        logic [ADDR_W-1:0] slot;
        r = '0;
        func_seen[op.func]++;
        case (op.func)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
                if (model_count >= CNT_W'(DEPTH)) begin
                    r.status = ST_OVERFLOW;
                end else if (op.func == FN_PUSH_FRONT) begin
                    model_front = model_front - 1'b1;
                    model_store[model_front] = op.value;
                    model_count++;
                end else begin
                    slot = ADDR_W'((int'(model_front) + int'(model_count)) % DEPTH);
                    model_store[slot] = op.value;
                    model_count++;
                end
            end
            FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK: begin
                if (model_count == 0) begin
                    r.status = ST_UNDERFLOW;
                end else if (op.func == FN_POP_FRONT || op.func == FN_PEEK_FRONT) begin
                    r.data = model_store[model_front];
                    if (op.func == FN_POP_FRONT) begin
                        model_front = model_front + 1'b1;
                        model_count--;
                    end
                end else begin
                    slot = ADDR_W'((int'(model_front) + int'(model_count) - 1) % DEPTH);
                    r.data = model_store[slot];
                    if (op.func == FN_POP_BACK) begin
                        model_count--;
                    end
                end
            end
            FN_SEARCH: begin
                for (int i = 0; i < int'(model_count); i++) begin
                    slot = ADDR_W'((int'(model_front) + i) % DEPTH);
                    if (model_store[slot] == op.value) begin
                        r.found = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.occupancy = OCC_W'(model_count);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("mismatch at beat %0d: %s", beats_out, msg);
    endtask

    // input driver; the predictor runs on every accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predicted_replies.push_back(deque_apply(i_in_data));
                beats_in++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_ops.size() > 0 && (quiet || $urandom_range(0, 99) >= 37)) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_ops.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and ready generator
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= quiet || ($urandom_range(0, 99) >= 37);
            if (o_out_valid && i_out_ready) begin
                beats_out++;
                if (predicted_replies.size() == 0) begin
                    report_mismatch("reply with no operation outstanding");
                end else begin
                    want = predicted_replies.pop_front();
                    if (o_out_data.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_out_data.status, want.status));
                    if (o_out_data.data !== want.data)
                        report_mismatch($sformatf("data %0d, expected %0d",
                                                  o_out_data.data, want.data));
                    if (o_out_data.found !== want.found)
                        report_mismatch($sformatf("found %b, expected %b",
                                                  o_out_data.found, want.found));
                    if (o_out_data.occupancy !== want.occupancy)
                        report_mismatch($sformatf("occupancy %0d, expected %0d",
                                                  o_out_data.occupancy, want.occupancy));
                    if (want.status == ST_UNDERFLOW) underflows++;
                    if (want.status == ST_OVERFLOW) overflows++;
                    if (want.found) search_hits++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0;
            3:       return 32'hffff_ffff;
            4:       return DATA_W'($urandom_range(0, 7));
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_op(input t_func f, input logic [DATA_W-1:0] v);
        t_in op;
        op.func  = f;
        op.value = v;
        pending_ops.push_back(op);
    endtask

    initial begin
        logic [DATA_W-1:0] pushed[$];
        logic [DATA_W-1:0] v;
        int                roll;
        int                fill_mode;
        int                mode_left;
        logic              timed_out;

        timed_out = 1'b0;
        fill_mode = 1;
        mode_left = 40;

        // empty queue corners
        queue_op(FN_POP_FRONT, 32'h0);
        queue_op(FN_POP_BACK, 32'hffff_ffff);
        queue_op(FN_PEEK_FRONT, 32'h0);
        queue_op(FN_PEEK_BACK, 32'h0);
        queue_op(FN_SEARCH, 32'h0);
        queue_op(FN_NOP, 32'hffff_ffff);
        // fill to the top from both ends, the last accepted push landing at the back
        queue_op(FN_PUSH_FRONT, 32'h8000_0000);
        queue_op(FN_PUSH_BACK, 32'h7fff_ffff);
        for (int i = 0; i < DEPTH - 3; i++) begin
            queue_op(i[0] ? FN_PUSH_FRONT : FN_PUSH_BACK, i[1] ? 32'h5555_5555 : 32'haaaa_aaaa);
        end
        queue_op(FN_PUSH_BACK, 32'h1234_5678);
        queue_op(FN_PUSH_BACK, 32'h0);
        queue_op(FN_PUSH_FRONT, 32'h0);
        queue_op(FN_SEARCH, 32'h1234_5678);
        queue_op(FN_SEARCH, 32'h0);
        queue_op(FN_PEEK_FRONT, 32'h0);
        queue_op(FN_PEEK_BACK, 32'h0);
        queue_op(FN_POP_BACK, 32'h0);
        queue_op(FN_POP_FRONT, 32'h0);

        // random traffic, alternating fill-heavy and drain-heavy phases
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (mode_left == 0) begin
                fill_mode = !fill_mode;
                mode_left = $urandom_range(20, 60);
            end
            mode_left--;
            roll = $urandom_range(0, 99);
            if (roll < 1) begin
                queue_op(FN_NOP, $urandom());
            end else if (roll < (fill_mode ? 55 : 20)) begin
                v = pick_value();
                pushed.push_back(v);
                if (pushed.size() > 32) void'(pushed.pop_front());
                queue_op($urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK, v);
            end else if (roll < 75) begin
                queue_op($urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK, $urandom());
            end else if (roll < 85) begin
                queue_op($urandom_range(0, 1) ? FN_PEEK_FRONT : FN_PEEK_BACK, $urandom());
            end else begin
                if (pushed.size() > 0 && $urandom_range(0, 9) < 6)
                    v = pushed[$urandom_range(0, pushed.size() - 1)];
                else
                    v = pick_value();
                queue_op(FN_SEARCH, v);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((pending_ops.size() > 0 || i_in_valid || predicted_replies.size() > 0)
               && !timed_out) begin
            @(posedge i_clk);
            if (stall_cycles >= STALL_LIMIT) timed_out = 1'b1;
        end

        if (timed_out) begin
            $display("timeout: %0d replies outstanding", predicted_replies.size());
            $display("CHECK FAILED");
        end else begin
            repeat (DRAIN_WAIT) @(posedge i_clk);
            $display("%0d beats in, %0d out: push %0d/%0d pop %0d/%0d peek %0d/%0d",
                     beats_in, beats_out, func_seen[FN_PUSH_FRONT], func_seen[FN_PUSH_BACK],
                     func_seen[FN_POP_FRONT], func_seen[FN_POP_BACK],
                     func_seen[FN_PEEK_FRONT], func_seen[FN_PEEK_BACK]);
            $display("search %0d (%0d hits), nop %0d, underflow %0d, overflow %0d, errors %0d",
                     func_seen[FN_SEARCH], search_hits, func_seen[FN_NOP],
                     underflows, overflows, errors);
            if (errors == 0 && predicted_replies.size() == 0) begin
                $display("CHECK OK");
            end else begin
                $display("CHECK FAILED");
            end
        end
        $finish;
    end

endmodule

`default_nettype wire
